// File: rtl/ght_pkg.sv
package ght_pkg;

  localparam int THREADS  = 4;
  localparam int SLOTS    = 64;
  localparam int GEN_W    = 16;
  localparam int THR_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int HINT_W   = 7;
  localparam int ADDR_W   = THR_W + SLOT_W;
  localparam int ENTRIES  = THREADS * SLOTS;

  localparam logic [HINT_W-1:0] MAX_CLIENTS_RST = HINT_W'(64);
  localparam logic [HINT_W-1:0] SLOTS_LIM       = HINT_W'(SLOTS);
  localparam logic [GEN_W-1:0]  GEN_RST         = GEN_W'(1);

  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_VALIDATE = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [THR_W-1:0]  thread_index;
    logic [SLOT_W-1:0] slot_index;
    logic [GEN_W-1:0]  handle_generation;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] out_slot;
    logic [GEN_W-1:0]  out_generation;
    logic [THR_W-1:0]  out_thread;
    logic              handle_valid;
  } result_t;

endpackage

// File: rtl/generational_handle_table.sv
// Steps: allocate runs scan, check per slot tried (scan ends it when out of slots);
//   free/validate run lookup, resolve (lookup ends past limit); unknown kind ends in idle.
// Throughput: one command at a time; busy stays high until the result beat,
//   which appears on result for one cycle with done; the receiver cannot stall.
// Reset: synchronous, active high. Per-entry valid bits make every slot read
//   as free with generation 1 right away; no clearing pass. max_clients = 64.
module generational_handle_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ght_pkg::cmd_t                   cmd,
  output logic                            done,
  output ght_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ght_pkg::HINT_W-1:0]      cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_CHECK   = 5'b00100,
    S_LOOKUP  = 5'b01000,
    S_RESOLVE = 5'b10000
  } state_t;

  typedef struct packed {
    logic                      busy;
    logic [ght_pkg::GEN_W-1:0] gen;
  } entry_t;

  state_t                      state, state_next;
  ght_pkg::cmd_t               cmd_q, cmd_q_next;
  ght_pkg::result_t            res, res_next;
  logic                        done_q;
  logic                        done_next;
  logic [ght_pkg::HINT_W-1:0]  max_clients;
  logic [ght_pkg::HINT_W-1:0]  hint [ght_pkg::THREADS];
  logic [ght_pkg::HINT_W-1:0]  hint_next [ght_pkg::THREADS];
  logic [ght_pkg::HINT_W-1:0]  lim;

  // shared compare unit
  logic [ght_pkg::HINT_W-1:0]  cmp_a;
  logic                        cmp_lt;

  // slot memory
  entry_t                      mem [ght_pkg::ENTRIES];
  logic [ght_pkg::ENTRIES-1:0] ent_vld;
  logic                        mem_we;
  logic [ght_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  entry_t                      mem_wdata;
  entry_t                      rd_q;
  logic                        rd_vld;
  logic                        cur_busy;
  logic [ght_pkg::GEN_W-1:0]   cur_gen, gen_inc;
  logic [ght_pkg::HINT_W-1:0]  cur_hint;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign done      = done_q;
  assign result    = res;

  assign lim      = (max_clients > ght_pkg::SLOTS_LIM) ? ght_pkg::SLOTS_LIM : max_clients;
  assign cur_hint = hint[cmd_q.thread_index];
  assign cmp_a    = (state == S_SCAN) ? cur_hint : {1'b0, cmd_q.slot_index};
  assign cmp_lt   = (cmp_a < lim);

  // entry never written reads as free, generation 1
  assign cur_busy = rd_vld & rd_q.busy;
  assign cur_gen  = rd_vld ? rd_q.gen : ght_pkg::GEN_RST;
  assign gen_inc  = (cur_gen + ght_pkg::GEN_W'(1) == '0) ? ght_pkg::GEN_RST
                                                         : cur_gen + ght_pkg::GEN_W'(1);

  // sequencer
  always_comb begin
    state_next = state;
    cmd_q_next = cmd_q;
    res_next   = res;
    done_next  = 1'b0;
    hint_next  = hint;
    mem_we     = 1'b0;
    mem_waddr  = {cmd_q.thread_index, cmd_q.slot_index};
    mem_wdata  = '{busy: 1'b0, gen: gen_inc};
    mem_raddr  = {cmd_q.thread_index, cmd_q.slot_index};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          res_next   = '{status: ght_pkg::ST_BAD, out_slot: '0, out_generation: '0,
                         out_thread: cmd.thread_index, handle_valid: 1'b0};
          priority if (32'(cmd.thread_index) >= ght_pkg::THREADS) begin
            done_next = 1'b1;
          end else if (cmd.kind == ght_pkg::KIND_ALLOC) begin
            state_next = S_SCAN;
          end else if (cmd.kind == ght_pkg::KIND_FREE ||
                       cmd.kind == ght_pkg::KIND_VALIDATE) begin
            state_next = S_LOOKUP;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      S_SCAN: begin
        mem_raddr = {cmd_q.thread_index, cur_hint[ght_pkg::SLOT_W-1:0]};
        if (cmp_lt) begin
          hint_next[cmd_q.thread_index] = cur_hint + ght_pkg::HINT_W'(1);
          cmd_q_next.slot_index = cur_hint[ght_pkg::SLOT_W-1:0];
          state_next = S_CHECK;
        end else begin
          res_next.status = ght_pkg::ST_FULL;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!cur_busy) begin
          mem_we    = 1'b1;
          mem_wdata = '{busy: 1'b1, gen: cur_gen};
          res_next.status         = ght_pkg::ST_OK;
          res_next.out_slot       = cmd_q.slot_index;
          res_next.out_generation = cur_gen;
          res_next.handle_valid   = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_LOOKUP: begin
        if (cmp_lt) begin
          state_next = S_RESOLVE;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RESOLVE: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (cmd_q.kind == ght_pkg::KIND_FREE) begin
          if (cur_gen == cmd_q.handle_generation && cur_busy) begin
            mem_we = 1'b1;
            res_next.status = ght_pkg::ST_OK;
            if ({1'b0, cmd_q.slot_index} < cur_hint) begin
              hint_next[cmd_q.thread_index] = {1'b0, cmd_q.slot_index};
            end
          end
        end else if (cur_gen == cmd_q.handle_generation) begin
          res_next.status       = ght_pkg::ST_OK;
          res_next.handle_valid = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done_q      <= 1'b0;
      max_clients <= ght_pkg::MAX_CLIENTS_RST;
      for (int t = 0; t < ght_pkg::THREADS; t++) begin
        hint[t] <= '0;
      end
    end else begin
      state  <= state_next;
      done_q <= done_next;
      hint   <= hint_next;
      if (cfg_valid && cfg_ready) begin
        max_clients <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    res   <= res_next;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // per-entry written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld[mem_waddr] <= 1'b1;
      end
      rd_vld <= ent_vld[mem_raddr];
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while a command is still in flight");

  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind == ght_pkg::KIND_ALLOC) |=> busy)
    else $error("allocate did not start a scan");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CHECK || state == S_RESOLVE))
    else $error("slot memory written outside check or resolve");

  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur_hint <= ght_pkg::SLOTS_LIM))
    else $error("free hint ran past the slot count");

  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_lt) |=> (state == S_CHECK && cur_hint == $past(cur_hint) + 7'd1))
    else $error("scan did not advance the hint by one slot");

endmodule

// File: tb/generational_handle_table_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHURN_PAIRS    = 20;

  // one queued command; live_gen asks the driver to fill in the slot's current generation
  typedef struct {
    ght_pkg::cmd_t c;
    bit            live_gen;
  } handle_op_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       start     = 1'b0;
  logic                       busy;
  ght_pkg::cmd_t              cmd       = '0;
  logic                       done;
  ght_pkg::result_t           result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [ght_pkg::HINT_W-1:0] cfg_data  = '0;

  // shadow copy of the handle tables
  logic                       slot_taken [ght_pkg::THREADS][ght_pkg::SLOTS];
  logic [ght_pkg::GEN_W-1:0]  slot_gen   [ght_pkg::THREADS][ght_pkg::SLOTS];
  logic [ght_pkg::HINT_W-1:0] scan_hint  [ght_pkg::THREADS];
  logic [ght_pkg::HINT_W-1:0] client_limit;

  handle_op_t       pending_ops[$];
  ght_pkg::result_t expected_results[$];
  handle_op_t       next_op;
  ght_pkg::result_t want;
  int               burst_left;
  int               gap_left;
  bit               steady_issue = 1'b0;
  int               error_count  = 0;
  int               idle_cycles;

  generational_handle_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic reset_tables();
    for (int t = 0; t < ght_pkg::THREADS; t++) begin
      scan_hint[t] = '0;
      for (int s = 0; s < ght_pkg::SLOTS; s++) begin
        slot_taken[t][s] = 1'b0;
        slot_gen[t][s]   = ght_pkg::GEN_RST;
      end
    end
    client_limit = ght_pkg::MAX_CLIENTS_RST;
  endtask

  // applies one command to the shadow tables and returns the result it should give
  function automatic ght_pkg::result_t predict_handle_op(input ght_pkg::cmd_t c);
    ght_pkg::result_t          r;
    int unsigned               lim;
    int unsigned               t;
    int unsigned               s;
    logic [ght_pkg::GEN_W-1:0] g;
    bit                        granted;
    bit                        match;
    r            = '0;
    r.status     = ght_pkg::ST_BAD;
    r.out_thread = c.thread_index;
    lim          = (32'(client_limit) > ght_pkg::SLOTS) ? ght_pkg::SLOTS : 32'(client_limit);
    t            = 32'(c.thread_index);
    s            = 32'(c.slot_index);
    granted      = 1'b0;
    if (t < ght_pkg::THREADS) begin
      case (c.kind)
        ght_pkg::KIND_ALLOC: begin
          r.status = ght_pkg::ST_FULL;
          // hint moves past every slot tried, granted or not
          while (!granted && 32'(scan_hint[t]) < lim) begin
            s            = 32'(scan_hint[t]);
            scan_hint[t] = scan_hint[t] + ght_pkg::HINT_W'(1);
            if (!slot_taken[t][s]) begin
              slot_taken[t][s] = 1'b1;
              granted          = 1'b1;
              r.status         = ght_pkg::ST_OK;
              r.out_slot       = ght_pkg::SLOT_W'(s);
              r.out_generation = slot_gen[t][s];
              r.handle_valid   = 1'b1;
            end
          end
        end
        ght_pkg::KIND_FREE: begin
          if (s < lim && slot_gen[t][s] == c.handle_generation && slot_taken[t][s]) begin
            g = slot_gen[t][s] + ght_pkg::GEN_W'(1);
            if (g == '0) g = ght_pkg::GEN_RST;
            slot_gen[t][s]   = g;
            slot_taken[t][s] = 1'b0;
            if (s < 32'(scan_hint[t])) scan_hint[t] = ght_pkg::HINT_W'(s);
            r.status = ght_pkg::ST_OK;
          end
        end
        ght_pkg::KIND_VALIDATE: begin
          if (s < lim) begin
            match          = (slot_gen[t][s] == c.handle_generation);
            r.handle_valid = match;
            r.status       = match ? ght_pkg::ST_OK : ght_pkg::ST_BAD;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic queue_op(logic [1:0] k, int thr, int slot, int gen, bit live);
    handle_op_t op;
    op.c.kind              = k;
    op.c.thread_index      = ght_pkg::THR_W'(thr);
    op.c.slot_index        = ght_pkg::SLOT_W'(slot);
    op.c.handle_generation = ght_pkg::GEN_W'(gen);
    op.live_gen            = live;
    pending_ops.push_back(op);
  endtask

  // mostly live handles in range, some stale or out of range, a little noise
  task automatic queue_random_ops(int n, int lim);
    int sel;
    int thr;
    int slot;
    int gen;
    for (int i = 0; i < n; i++) begin
      sel  = $urandom_range(0, 99);
      thr  = $urandom_range(0, 3);
      slot = (lim > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, lim - 1)
                                                    : $urandom_range(0, 63);
      gen  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
      if (sel < 40)
        queue_op(ght_pkg::KIND_ALLOC, thr, $urandom_range(0, 63), $urandom_range(0, 65535),
                 1'b0);
      else if (sel < 70)
        queue_op(ght_pkg::KIND_FREE, thr, slot, gen, $urandom_range(0, 9) < 8);
      else if (sel < 90)
        queue_op(ght_pkg::KIND_VALIDATE, thr, slot, gen, $urandom_range(0, 9) < 7);
      else if (sel < 95)
        queue_op(ght_pkg::KIND_NONE, thr, slot, gen, 1'b0);
      else
        queue_op(2'($urandom_range(0, 3)), thr, $urandom_range(0, 63),
                 $urandom_range(0, 65535), 1'b0);
    end
  endtask

  // settle at falling edges so driver updates at the rising edge are complete
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_clients(logic [ght_pkg::HINT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    client_limit = v;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // command driver: bursts with random gaps (none while steady_issue is set); next command loads on the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (start && !busy) expected_results.push_back(predict_handle_op(cmd));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          next_op = pending_ops.pop_front();
          if (next_op.live_gen)
            next_op.c.handle_generation =
              slot_gen[next_op.c.thread_index][next_op.c.slot_index];
          cmd   <= next_op.c;
          start <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = steady_issue ? 0 : $urandom_range(0, 10);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: %p", result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("out_slot", 32'(want.out_slot), 32'(result.out_slot));
        check_field("out_generation", 32'(want.out_generation),
                    32'(result.out_generation));
        check_field("out_thread", 32'(want.out_thread), 32'(result.out_thread));
        check_field("handle_valid", 32'(want.handle_valid), 32'(result.handle_valid));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [ght_pkg::HINT_W-1:0] phase_limits [10];
    logic [ght_pkg::HINT_W-1:0] v;
    phase_limits = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd8, 7'd0, 7'd5, 7'd64, 7'd2, 7'd16};
    reset_tables();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh slot, grants, stale handles, double free, slot 63, unknown kind
    queue_op(ght_pkg::KIND_VALIDATE, 0, 0, 1, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 0, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 0, 63, 65535, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 3, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 0, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 0, 0, 65535, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 0, 0, 2, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 0, 0, 1, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 0, 0, 2, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 0, 0, 2, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 0, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 0, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_NONE, 2, 63, 65535, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 1, 63, 1, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 3, 0, 1, 1'b0);
    wait_idle();

    // small limit: out-of-range slots, running out, hint held at the limit
    write_max_clients(7'd2);
    queue_op(ght_pkg::KIND_VALIDATE, 0, 2, 1, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 0, 63, 1, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 1, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 1, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 1, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 1, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_FREE, 1, 1, 1, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 1, 0, 0, 1'b0);
    wait_idle();

    // zero limit: everything fails at once
    write_max_clients(7'd0);
    queue_op(ght_pkg::KIND_ALLOC, 2, 0, 0, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 2, 0, 1, 1'b0);
    wait_idle();

    // allocate/free churn on one slot, back-to-back; generation climbs each round
    write_max_clients(7'd1);
    steady_issue = 1'b1;
    for (int i = 0; i < CHURN_PAIRS; i++) begin
      queue_op(ght_pkg::KIND_ALLOC, 2, 0, 0, 1'b0);
      queue_op(ght_pkg::KIND_FREE, 2, 0, 0, 1'b1);
    end
    queue_op(ght_pkg::KIND_VALIDATE, 2, 0, 1, 1'b0);
    queue_op(ght_pkg::KIND_VALIDATE, 2, 0, CHURN_PAIRS + 1, 1'b0);
    queue_op(ght_pkg::KIND_ALLOC, 2, 0, 0, 1'b0);
    wait_idle();
    steady_issue = 1'b0;

    // random phases, each under its own limit
    for (int p = 0; p < 10; p++) begin
      v = (p == 9) ? ght_pkg::HINT_W'($urandom_range(0, 127)) : phase_limits[p];
      write_max_clients(v);
      queue_random_ops(95, (32'(v) > ght_pkg::SLOTS) ? ght_pkg::SLOTS : int'(v));
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
